[rtl/rpfe_pkg.sv]
// ----------------------------------------------------------------------------
// rpfe_pkg
// Shared types and constants for the RGBA pixel format encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rpfe_pkg;

    typedef enum logic [1:0] {
        FMT_RGBA8 = 2'd0,
        FMT_BGRA8 = 2'd1,
        FMT_HALF  = 2'd2,
        FMT_FLOAT = 2'd3
    } pix_fmt_t;

    localparam int unsigned LaneCount = 4;
    localparam int unsigned WordW     = 32;

    localparam logic [7:0]  ExpMax    = 8'hff;
    localparam logic [30:0] OneMag    = 31'h3f800000;
    // Below this exponent the scaled value stays under 0.5 and rounds to zero.
    localparam logic [7:0]  U8MinExp  = 8'd110;
    localparam logic [7:0]  U8OneExp  = 8'd127;
    localparam logic [7:0]  HalfBias  = 8'd112;
    localparam logic [7:0]  HalfSubLo = 8'd102;
    localparam logic [23:0] HalfRnd   = 24'h001000;
    localparam logic [4:0]  HalfExpInf = 5'h1f;

    typedef logic [WordW-1:0] word_t;

    typedef struct packed {
        logic     load;
        pix_fmt_t fmt;
    } lane_ctrl_t;

    typedef struct packed {
        logic s1_valid;
        logic out_ready;
    } mrg_ctrl_t;

endpackage

`default_nettype wire

[rtl/rpfe_lane.sv]
// ----------------------------------------------------------------------------
// rpfe_lane
// Encodes one channel: clamp and half/single conversion plus the x255 product
// in the first stage, unorm8 rounding and format selection in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfe_lane
    import rpfe_pkg::*;
(
    input  wire logic       clk,
    input  wire lane_ctrl_t ctrl,
    input  wire word_t      bits,
    output word_t           result
);

    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic        is_nan;
    logic        is_neg;
    logic        is_big;
    word_t       clamped;
    logic        vs;
    logic [7:0]  ve;
    logic [22:0] vm;
    logic [15:0] half_val;
    logic [23:0] sub_shift;
    logic [24:0] sub_sum;
    logic [23:0] nrm_sum;
    logic [4:0]  hex;
    logic [10:0] hm;
    logic [3:0]  sub_amt;
    logic [31:0] prod;
    logic        u8_zero;
    logic        u8_full;

    pix_fmt_t    fmt_reg;
    logic [15:0] half_reg;
    word_t       single_reg;
    logic        u8_zero_reg;
    logic        u8_full_reg;
    logic [31:0] prod_reg;
    logic [7:0]  exp_reg;

    always_comb
    begin
        sgn     = bits[31];
        ex      = bits[30:23];
        man     = bits[22:0];
        is_nan  = (ex == ExpMax) && (man != 23'd0);
        is_neg  = sgn && (bits[30:0] != 31'd0) && !is_nan;
        is_big  = !sgn && (bits[30:0] > OneMag) && !is_nan;
        clamped = is_neg ? '0 : (is_big ? {1'b0, OneMag} : bits);
        vs = clamped[31];
        ve = clamped[30:23];
        vm = clamped[22:0];

        sub_amt   = 4'(HalfBias + 8'd1 - ve);
        sub_shift = {1'b1, vm} >> sub_amt;
        sub_sum   = {1'b0, sub_shift} + {1'b0, HalfRnd};
        nrm_sum   = {1'b0, vm} + HalfRnd;
        hm        = nrm_sum[23:13];
        hex       = 5'(ve - HalfBias);
        if (hm[10])
        begin
            hex = hex + 5'd1;
            hm  = '0;
        end

        if (ve == ExpMax)
        begin
            half_val = {vs, HalfExpInf, 10'd0};
        end
        else if (ve <= HalfBias)
        begin
            if (ve < HalfSubLo)
                half_val = {vs, 15'd0};
            else
                half_val = {vs, 3'd0, sub_sum[24:13]};
        end
        else
        begin
            half_val = {vs, hex, hm[9:0]};
        end

        // Product of the full significand with 255, exact in 32 bits.
        prod    = {1'b1, man, 8'd0} - {8'd0, 1'b1, man};
        u8_zero = is_nan || sgn || (bits[30:0] == 31'd0) || (ex < U8MinExp);
        u8_full = !is_nan && !sgn && (ex >= U8OneExp);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            fmt_reg     <= ctrl.fmt;
            half_reg    <= half_val;
            single_reg  <= clamped;
            u8_zero_reg <= u8_zero;
            u8_full_reg <= u8_full;
            prod_reg    <= prod;
            exp_reg     <= ex;
        end
    end

    logic [23:0] keep;
    logic        rnd;
    logic [24:0] kept;
    logic [32:0] prod_rnd;
    logic [5:0]  sh_amt;
    logic [32:0] shifted;
    logic [8:0]  n_val;
    logic [7:0]  u8_val;

    always_comb
    begin
        // Round the product to single precision, nearest even.
        if (prod_reg[31])
        begin
            keep     = prod_reg[31:8];
            rnd      = prod_reg[7] && ((prod_reg[6:0] != 7'd0) || prod_reg[8]);
            kept     = {1'b0, keep} + {24'd0, rnd};
            prod_rnd = {kept, 8'd0};
        end
        else
        begin
            keep     = prod_reg[30:7];
            rnd      = prod_reg[6] && ((prod_reg[5:0] != 6'd0) || prod_reg[7]);
            kept     = {1'b0, keep} + {24'd0, rnd};
            prod_rnd = {1'b0, kept, 7'd0};
        end
        // Keep one fraction bit below the integer part for half-up rounding.
        sh_amt  = 6'(8'd149 - exp_reg);
        shifted = prod_rnd >> sh_amt;
        n_val   = shifted[9:1] + {8'd0, shifted[0]};
        if (u8_zero_reg)
            u8_val = 8'd0;
        else if (u8_full_reg)
            u8_val = 8'd255;
        else
            u8_val = n_val[7:0];

        unique case (fmt_reg)
            FMT_RGBA8, FMT_BGRA8: result = {24'd0, u8_val};
            FMT_HALF:             result = {16'd0, half_reg};
            FMT_FLOAT:            result = single_reg;
            default:              result = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/rpfe_merge.sv]
// ----------------------------------------------------------------------------
// rpfe_merge
// Output register stage that gathers the four lane results into one request.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfe_merge
    import rpfe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mrg_ctrl_t ctrl,
    input  wire word_t     lane_res [LaneCount],
    output logic           out_free,
    output logic           out_valid,
    output word_t          lane_out [LaneCount]
);

    logic out_valid_reg;
    logic out_valid_next;
    word_t lane_reg [LaneCount];

    assign out_free       = !out_valid_reg || ctrl.out_ready;
    assign out_valid_next = out_free ? ctrl.s1_valid : 1'b1;
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && ctrl.s1_valid)
            lane_reg <= lane_res;
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

[rtl/rgba_pixel_format_encoder.sv]
// ----------------------------------------------------------------------------
// rgba_pixel_format_encoder
// Packs one float32 RGBA pixel into rgba8, bgra8, half or single storage.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock unless the output stalls and delivers it from
// the output register; four lane encoders run in parallel, each registering
// the clamp and x255 product and then rounding into the shared output
// register. A stalled output holds the pipeline. The format register is
// sampled with each pixel, so write it only while the block is idle.
`default_nettype none

module rgba_pixel_format_encoder
    import rpfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  pixel_format,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] red_bits,
    input  wire logic [31:0] green_bits,
    input  wire logic [31:0] blue_bits,
    input  wire logic [31:0] alpha_bits,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      lane_zero,
    output logic [31:0]      lane_one,
    output logic [31:0]      lane_two,
    output logic [31:0]      lane_three
);

    pix_fmt_t   fmt_reg;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       out_free;
    logic       load;
    lane_ctrl_t lctrl;
    mrg_ctrl_t  mctrl;
    word_t      lane_in  [LaneCount];
    word_t      lane_res [LaneCount];
    word_t      lane_out [LaneCount];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_RGBA8;
        else if (cfg_valid)
            fmt_reg <= pix_fmt_t'(pixel_format);
    end

    assign in_ready      = !s1_valid_reg || out_free;
    assign load          = in_valid && in_ready;
    assign s1_valid_next = load ? 1'b1 : (out_free ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // bgra8 swaps red and blue in memory order.
    always_comb
    begin
        lane_in[0] = (fmt_reg == FMT_BGRA8) ? blue_bits : red_bits;
        lane_in[1] = green_bits;
        lane_in[2] = (fmt_reg == FMT_BGRA8) ? red_bits : blue_bits;
        lane_in[3] = alpha_bits;
        lctrl.load = load;
        lctrl.fmt  = fmt_reg;
        mctrl.s1_valid  = s1_valid_reg;
        mctrl.out_ready = out_ready;
    end

    for (genvar i = 0; i < LaneCount; i++)
    begin : g_lane
        rpfe_lane u_lane (
            .clk    (clk),
            .ctrl   (lctrl),
            .bits   (lane_in[i]),
            .result (lane_res[i])
        );
    end

    rpfe_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mctrl),
        .lane_res (lane_res),
        .out_free (out_free),
        .out_valid(out_valid),
        .lane_out (lane_out)
    );

    assign lane_zero  = lane_out[0];
    assign lane_one   = lane_out[1];
    assign lane_two   = lane_out[2];
    assign lane_three = lane_out[3];

endmodule

`default_nettype wire

[rtl/rpfe_checker.sv]
// ----------------------------------------------------------------------------
// rpfe_checker
// Port-level checks for the RGBA pixel format encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfe_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_ready,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] lane_zero
);

    // With no result pending, the pipeline can always take a new request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("in_ready low with output empty");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready) else $error("cfg_ready dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("out_valid dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(lane_zero)) else $error("lane changed");

endmodule

bind rgba_pixel_format_encoder rpfe_checker u_rpfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .lane_zero (lane_zero)
);

`default_nettype wire
